// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the port checker (bsla_checker) of this project.
// Expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an implication holds at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Check that a condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

`endif

// ----- hw/rtl/bsla_pkg.sv -----
// Shared types and constants for the beam sensor lateral align sequencer.
// No dependencies; used by the top level, its checker and the testbench.
`default_nettype none

package bsla_pkg;

	// Request codes
	typedef enum logic [1:0] {
		REQ_START = 2'd0,
		REQ_TICK  = 2'd1,
		REQ_STOP  = 2'd2
	} req_t;

	// Run states
	typedef enum logic [1:0] {
		ST_MANUAL   = 2'd0,
		ST_ALIGNING = 2'd1,
		ST_ARRIVED  = 2'd2,
		ST_FAULT    = 2'd3
	} run_state_t;

	// Error codes
	typedef enum logic [2:0] {
		ERR_NONE    = 3'd0,
		ERR_SENSOR  = 3'd1,
		ERR_TIMEOUT = 3'd2,
		ERR_BOTH    = 3'd3,
		ERR_YAW     = 3'd4
	} err_t;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SETTLE         = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_TIMEOUT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_TIMEOUT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_MAG      = 3'd4;

	localparam int CFG_DATA_W = 16;
	localparam int MAG_W      = 15;

	// Register values after reset
	localparam logic [15:0]      RST_DEBOUNCE       = 16'd200;
	localparam logic [15:0]      RST_SETTLE         = 16'd150;
	localparam logic [15:0]      RST_TOTAL_TIMEOUT  = 16'd2500;
	localparam logic [15:0]      RST_SENSOR_TIMEOUT = 16'd300;
	localparam logic [MAG_W-1:0] RST_DRIVE_MAG      = 15'd15;

	// Beam patterns
	localparam logic [1:0] PAT_CLEAR = 2'b00;
	localparam logic [1:0] PAT_LEFT  = 2'b01;
	localparam logic [1:0] PAT_RIGHT = 2'b10;

	// One request
	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] now_ms;
		logic        imu_ok;
		logic        left_online;
		logic        right_online;
		logic [31:0] left_rx_ms;
		logic [31:0] right_rx_ms;
		logic        left_beam;
		logic        right_beam;
	} req_item_t;

	// One result
	typedef struct packed {
		logic               drive_valid;
		logic signed [15:0] drive_x;
		logic [1:0]         run_state_out;
		logic [2:0]         error_code;
		logic               manual_request;
	} result_item_t;

endpackage

`default_nettype wire

// ----- hw/rtl/beam_sensor_lateral_align_sequencer.sv -----
// An accepted request goes through the input register and then the result register.
// Throughput: one request per cycle unless the result channel stalls; all decisions are
// compares and 32-bit modular subtractions in a single stage between input and result registers.
// Reset: asynchronous, active low; clears run state, error, timing state and valid
// flags, and loads the configuration registers with their default values.
`default_nettype none

module beam_sensor_lateral_align_sequencer (
	input  wire                                     clk,
	input  wire                                     arst_n,
	// request channel
	input  wire                                     item_valid,
	output logic                                    item_stall,
	input  bsla_pkg::req_item_t                     item,
	// result channel
	output logic                                    result_valid,
	input  wire                                     result_stall,
	output bsla_pkg::result_item_t                  result,
	// configuration writes
	input  wire                                     cfg_we,
	input  wire  [bsla_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  wire  [bsla_pkg::CFG_DATA_W-1:0]         cfg_data
);

	// Configuration registers
	logic [15:0]                  debounce_q;
	logic [15:0]                  settle_q;
	logic [15:0]                  total_timeout_q;
	logic [15:0]                  sensor_timeout_q;
	logic [bsla_pkg::MAG_W-1:0]   drive_mag_q;

	// Sequencer state
	bsla_pkg::run_state_t run_state_q, run_state_nxt;
	bsla_pkg::err_t       error_q, error_nxt;
	logic [31:0]          begin_time_q, begin_time_nxt;
	logic [31:0]          pattern_since_q, pattern_since_nxt;
	logic [1:0]           last_pattern_q, last_pattern_nxt;
	logic                 pattern_known_q, pattern_known_nxt;

	// Input stage
	logic                 valid_s1;
	bsla_pkg::req_item_t  item_s1;
	logic                 adv_s1;

	// Decode of the staged request
	logic [31:0]          left_age, right_age, run_age, stable_age;
	logic                 sensor_bad, run_timeout;
	logic [1:0]           pat;
	logic                 fresh_pat;
	logic                 settled, debounced;
	logic                 is_tick_aligning;

	bsla_pkg::result_item_t res_nxt;
	logic                   result_valid_q;
	bsla_pkg::result_item_t result_q;

	// Move the staged request on when the result register is free or being emptied
	assign adv_s1     = valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall = valid_s1 && !adv_s1;

	// Configuration write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q       <= bsla_pkg::RST_DEBOUNCE;
			settle_q         <= bsla_pkg::RST_SETTLE;
			total_timeout_q  <= bsla_pkg::RST_TOTAL_TIMEOUT;
			sensor_timeout_q <= bsla_pkg::RST_SENSOR_TIMEOUT;
			drive_mag_q      <= bsla_pkg::RST_DRIVE_MAG;
		end else if (cfg_we) begin
			case (cfg_index)
				bsla_pkg::CFG_DEBOUNCE:       debounce_q       <= cfg_data;
				bsla_pkg::CFG_SETTLE:         settle_q         <= cfg_data;
				bsla_pkg::CFG_TOTAL_TIMEOUT:  total_timeout_q  <= cfg_data;
				bsla_pkg::CFG_SENSOR_TIMEOUT: sensor_timeout_q <= cfg_data;
				bsla_pkg::CFG_DRIVE_MAG:      drive_mag_q      <= cfg_data[bsla_pkg::MAG_W-1:0];
				default: ;
			endcase
		end
	end

	// Capture an accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	// Ages and checks, all modulo 2^32
	always_comb begin
		left_age   = item_s1.now_ms - item_s1.left_rx_ms;
		right_age  = item_s1.now_ms - item_s1.right_rx_ms;
		run_age    = item_s1.now_ms - begin_time_q;
		stable_age = item_s1.now_ms - pattern_since_q;
		sensor_bad = !item_s1.left_online || !item_s1.right_online ||
			(left_age > {16'd0, sensor_timeout_q}) ||
			(right_age > {16'd0, sensor_timeout_q});
		run_timeout = run_age > {16'd0, total_timeout_q};
		pat         = {item_s1.right_beam, item_s1.left_beam};
		fresh_pat   = !pattern_known_q || (pat != last_pattern_q);
		settled     = stable_age >= {16'd0, settle_q};
		debounced   = stable_age >= {16'd0, debounce_q};
		is_tick_aligning = (item_s1.req_type == bsla_pkg::REQ_TICK) &&
			(run_state_q == bsla_pkg::ST_ALIGNING);
	end

	// Next state
	always_comb begin
		run_state_nxt     = run_state_q;
		error_nxt         = error_q;
		begin_time_nxt    = begin_time_q;
		pattern_since_nxt = pattern_since_q;
		last_pattern_nxt  = last_pattern_q;
		pattern_known_nxt = pattern_known_q;
		case (item_s1.req_type)
			bsla_pkg::REQ_START: begin
				if (!item_s1.imu_ok) begin
					run_state_nxt = bsla_pkg::ST_FAULT;
					error_nxt     = bsla_pkg::ERR_YAW;
				end else begin
					begin_time_nxt    = item_s1.now_ms;
					pattern_since_nxt = item_s1.now_ms;
					pattern_known_nxt = 1'b0;
					run_state_nxt     = bsla_pkg::ST_ALIGNING;
					error_nxt         = bsla_pkg::ERR_NONE;
				end
			end
			bsla_pkg::REQ_STOP: begin
				run_state_nxt = bsla_pkg::ST_MANUAL;
				error_nxt     = bsla_pkg::ERR_NONE;
			end
			bsla_pkg::REQ_TICK: begin
				if (is_tick_aligning) begin
					if (sensor_bad) begin
						run_state_nxt = bsla_pkg::ST_FAULT;
						error_nxt     = bsla_pkg::ERR_SENSOR;
					end else if (run_timeout) begin
						run_state_nxt = bsla_pkg::ST_FAULT;
						error_nxt     = bsla_pkg::ERR_TIMEOUT;
					end else if (fresh_pat) begin
						last_pattern_nxt  = pat;
						pattern_since_nxt = item_s1.now_ms;
						pattern_known_nxt = 1'b1;
					end else if (pat == bsla_pkg::PAT_CLEAR) begin
						if (settled) begin
							run_state_nxt = bsla_pkg::ST_ARRIVED;
							error_nxt     = bsla_pkg::ERR_NONE;
						end
					end else if (debounced && pat != bsla_pkg::PAT_LEFT &&
						pat != bsla_pkg::PAT_RIGHT) begin
						run_state_nxt = bsla_pkg::ST_FAULT;
						error_nxt     = bsla_pkg::ERR_BOTH;
					end
				end
			end
			default: ;
		endcase
	end

	// Result fields
	always_comb begin
		res_nxt.drive_valid    = 1'b0;
		res_nxt.drive_x        = '0;
		res_nxt.manual_request = 1'b0;
		case (item_s1.req_type)
			bsla_pkg::REQ_STOP: begin
				res_nxt.manual_request = 1'b1;
			end
			bsla_pkg::REQ_TICK: begin
				if (is_tick_aligning) begin
					if (sensor_bad || run_timeout) begin
						res_nxt.manual_request = 1'b1;
					end else if (!fresh_pat) begin
						if (pat == bsla_pkg::PAT_CLEAR) begin
							res_nxt.manual_request = settled;
						end else if (debounced) begin
							if (pat == bsla_pkg::PAT_LEFT) begin
								res_nxt.drive_valid = 1'b1;
								res_nxt.drive_x     = $signed({1'b0, drive_mag_q});
							end else if (pat == bsla_pkg::PAT_RIGHT) begin
								res_nxt.drive_valid = 1'b1;
								res_nxt.drive_x     = -$signed({1'b0, drive_mag_q});
							end else begin
								res_nxt.manual_request = 1'b1;
							end
						end
					end
				end
			end
			default: ;
		endcase
		res_nxt.run_state_out = run_state_nxt;
		res_nxt.error_code    = error_nxt;
	end

	// Commit state when the request moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_state_q     <= bsla_pkg::ST_MANUAL;
			error_q         <= bsla_pkg::ERR_NONE;
			begin_time_q    <= '0;
			pattern_since_q <= '0;
			last_pattern_q  <= '0;
			pattern_known_q <= 1'b0;
		end else if (adv_s1) begin
			run_state_q     <= run_state_nxt;
			error_q         <= error_nxt;
			begin_time_q    <= begin_time_nxt;
			pattern_since_q <= pattern_since_nxt;
			last_pattern_q  <= last_pattern_nxt;
			pattern_known_q <= pattern_known_nxt;
		end
	end

	// Result register: load on advance, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv_s1) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			result_q <= res_nxt;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

// ----- hw/rtl/bsla_checker.sv -----
// Port-level checks for the beam sensor lateral align sequencer.
// Depends on bsla_pkg and assert_macros.svh; bound to the top level below.
`default_nettype none
`include "assert_macros.svh"

module bsla_checker (
	input wire                                  clk,
	input wire                                  arst_n,
	input wire                                  result_valid,
	input wire                                  result_stall,
	input bsla_pkg::result_item_t               result
);

	// A stalled result stays put
	`ASSERT_CLK(a_result_hold, result_valid && result_stall |=> result_valid && $stable(result), "result changed while stalled")

	// No drive command without drive request
	`ASSERT_CLK(a_idle_zero, result_valid && !result.drive_valid |-> result.drive_x == 16'sd0, "drive_x nonzero while released")

	// A drive only comes from a healthy aligning run
	`ASSERT_CLK(a_drive_aligning, result_valid && result.drive_valid |-> result.run_state_out == bsla_pkg::ST_ALIGNING && result.error_code == bsla_pkg::ERR_NONE && !result.manual_request, "drive outside a healthy run")

	// Any reported error means the run sits in fault
	`ASSERT_CLK(a_error_fault, result_valid && result.error_code != bsla_pkg::ERR_NONE |-> result.run_state_out == bsla_pkg::ST_FAULT, "error without fault state")

	// Handing control back never leaves the run aligning
	`ASSERT_CLK(a_manual_ends, result_valid && result.manual_request |-> result.run_state_out != bsla_pkg::ST_ALIGNING, "manual request while aligning")

endmodule

bind beam_sensor_lateral_align_sequencer bsla_checker u_bsla_checker (.*);

`default_nettype wire

// ----- tb/bsla_result_checker.sv -----
// Result checker for the beam sensor lateral align sequencer: watches the request,
// result and configuration ports, predicts each result and compares it field by field.
// Depends on bsla_pkg for the request, result, state and error types.
`timescale 1ns / 1ps

module bsla_result_checker
	import bsla_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	input  logic                  item_stall,
	input  req_item_t             item,
	input  logic                  result_valid,
	input  logic                  result_stall,
	input  result_item_t          result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    pending
);

	// Shadow of the configuration registers
	logic [15:0]      debounce_lim;
	logic [15:0]      settle_lim;
	logic [15:0]      run_limit;
	logic [15:0]      age_limit;
	logic [MAG_W-1:0] drive_mag;

	// Shadow of the sequencer state
	run_state_t  run_st;
	err_t        err_st;
	logic [31:0] begin_ms;
	logic [31:0] since_ms;
	logic [1:0]  held_pat;
	logic        pat_valid;

	result_item_t expected_results[$];
	result_item_t predicted;
	result_item_t oldest;

	// Count a failure; only the first few are printed
	task note_failure(input string msg);
		begin
			fail_count++;
			if (fail_count <= 10)
				$display("%0t: %s", $realtime, msg);
		end
	endtask

	task check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		begin
			if (got !== want)
				note_failure($sformatf("%s mismatch: expected %h, got %h", name, want, got));
		end
	endtask

	// Advance the sequencer shadow by one request and build the result it causes
	task align_step(input req_item_t r, output result_item_t res);
		logic [1:0]  pat;
		logic [31:0] stable;
		begin
			res = '0;
			pat = {r.right_beam, r.left_beam};
			case (r.req_type)
				REQ_START: begin
					if (!r.imu_ok) begin
						run_st = ST_FAULT;
						err_st = ERR_YAW;
					end else begin
						begin_ms  = r.now_ms;
						since_ms  = r.now_ms;
						pat_valid = 1'b0;
						run_st    = ST_ALIGNING;
						err_st    = ERR_NONE;
					end
				end
				REQ_STOP: begin
					run_st = ST_MANUAL;
					err_st = ERR_NONE;
					res.manual_request = 1'b1;
				end
				REQ_TICK: begin
					if (run_st == ST_ALIGNING) begin
						// sensor health first, then overall run time, then the beam pattern
						if (!r.left_online || !r.right_online ||
								(r.now_ms - r.left_rx_ms) > {16'd0, age_limit} ||
								(r.now_ms - r.right_rx_ms) > {16'd0, age_limit}) begin
							run_st = ST_FAULT;
							err_st = ERR_SENSOR;
							res.manual_request = 1'b1;
						end else if ((r.now_ms - begin_ms) > {16'd0, run_limit}) begin
							run_st = ST_FAULT;
							err_st = ERR_TIMEOUT;
							res.manual_request = 1'b1;
						end else if (!pat_valid || pat != held_pat) begin
							held_pat  = pat;
							since_ms  = r.now_ms;
							pat_valid = 1'b1;
						end else begin
							stable = r.now_ms - since_ms;
							if (pat == PAT_CLEAR) begin
								if (stable >= {16'd0, settle_lim}) begin
									run_st = ST_ARRIVED;
									err_st = ERR_NONE;
									res.manual_request = 1'b1;
								end
							end else if (stable >= {16'd0, debounce_lim}) begin
								if (pat == PAT_LEFT) begin
									res.drive_valid = 1'b1;
									res.drive_x     = $signed({1'b0, drive_mag});
								end else if (pat == PAT_RIGHT) begin
									res.drive_valid = 1'b1;
									res.drive_x     = 16'sd0 - $signed({1'b0, drive_mag});
								end else begin
									run_st = ST_FAULT;
									err_st = ERR_BOTH;
									res.manual_request = 1'b1;
								end
							end
						end
					end
				end
				default: ;
			endcase
			res.run_state_out = run_st;
			res.error_code    = err_st;
		end
	endtask

	// Compare results, track configuration writes, predict accepted requests
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_lim = RST_DEBOUNCE;
			settle_lim   = RST_SETTLE;
			run_limit    = RST_TOTAL_TIMEOUT;
			age_limit    = RST_SENSOR_TIMEOUT;
			drive_mag    = RST_DRIVE_MAG;
			run_st       = ST_MANUAL;
			err_st       = ERR_NONE;
			begin_ms     = '0;
			since_ms     = '0;
			held_pat     = PAT_CLEAR;
			pat_valid    = 1'b0;
			expected_results.delete();
			pending      = 0;
			fail_count   = 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_results.size() == 0) begin
					note_failure("result with no request waiting for it");
				end else begin
					oldest = expected_results.pop_front();
					check_field("drive_valid", oldest.drive_valid, result.drive_valid);
					check_field("drive_x", oldest.drive_x, result.drive_x);
					check_field("run_state_out", oldest.run_state_out, result.run_state_out);
					check_field("error_code", oldest.error_code, result.error_code);
					check_field("manual_request", oldest.manual_request,
						result.manual_request);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_DEBOUNCE:       debounce_lim = cfg_data;
					CFG_SETTLE:         settle_lim   = cfg_data;
					CFG_TOTAL_TIMEOUT:  run_limit    = cfg_data;
					CFG_SENSOR_TIMEOUT: age_limit    = cfg_data;
					CFG_DRIVE_MAG:      drive_mag    = cfg_data[MAG_W-1:0];
					default: ;
				endcase
			end
			if (item_valid && !item_stall) begin
				align_step(item, predicted);
				expected_results.push_back(predicted);
			end
			pending = expected_results.size();
		end
	end

endmodule

// ----- tb/tb.sv -----
// Top of the testbench for the beam sensor lateral align sequencer: clock, reset,
// request and configuration stimulus, receiver stalls and the final verdict.
// Depends on bsla_pkg, the sequencer RTL and bsla_result_checker.
`timescale 1ns / 1ps

module tb;
	import bsla_pkg::*;

	// Request type that the block ignores
	localparam logic [1:0] REQ_NONE = 2'd3;

	logic                  clk;
	logic                  arst_n;
	logic                  item_valid;
	logic                  item_stall;
	req_item_t             item;
	logic                  result_valid;
	logic                  result_stall;
	result_item_t          result;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    fail_count;
	int                    pending;

	int          tx_idle_pct;
	int          rx_idle_pct;
	int          hold_left;
	int          sent_count;
	int          step_max;
	logic [15:0] reg_val [5];

	beam_sensor_lateral_align_sequencer u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	bsla_result_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop if the run hangs
	initial begin
		#5ms;
		$display("tb NOT OK");
		$finish;
	end

	// Receiver: random stalls, or a long hold-off when one is requested
	always @(negedge clk) begin
		if (hold_left > 0) begin
			result_stall = 1'b1;
			hold_left--;
		end else begin
			result_stall = ($urandom_range(99) < rx_idle_pct);
		end
	end

	function automatic req_item_t mk_req(input logic [1:0] req, input logic [31:0] now,
			input logic imu, input logic lon, input logic ron,
			input logic [31:0] lrx, input logic [31:0] rrx,
			input logic lb, input logic rb);
		req_item_t r;
		r.req_type     = req;
		r.now_ms       = now;
		r.imu_ok       = imu;
		r.left_online  = lon;
		r.right_online = ron;
		r.left_rx_ms   = lrx;
		r.right_rx_ms  = rrx;
		r.left_beam    = lb;
		r.right_beam   = rb;
		return r;
	endfunction

	// Tick with mostly fresh sensor data; sometimes stale, offline or garbage
	function automatic req_item_t mk_tick(input logic [31:0] now, input logic [1:0] pat);
		logic [31:0] rx [2];
		int          u;
		for (int s = 0; s < 2; s++) begin
			u = $urandom_range(99);
			if (u < 95)
				rx[s] = now - $urandom_range(0, reg_val[CFG_SENSOR_TIMEOUT]);
			else if (u < 98)
				rx[s] = now - (reg_val[CFG_SENSOR_TIMEOUT] + $urandom_range(1, 50));
			else
				rx[s] = $urandom();
		end
		return mk_req(REQ_TICK, now, $urandom_range(1), $urandom_range(99) >= 2,
			$urandom_range(99) >= 2, rx[0], rx[1], pat[0], pat[1]);
	endfunction

	function automatic req_item_t mk_noise();
		return mk_req($urandom_range(3), $urandom(), $urandom_range(1), $urandom_range(1),
			$urandom_range(1), $urandom(), $urandom(), $urandom_range(1), $urandom_range(1));
	endfunction

	// Offer one request and hold it until accepted
	task send_req(input req_item_t r);
		begin
			while ($urandom_range(99) < tx_idle_pct) begin
				@(negedge clk);
				item_valid = 1'b0;
			end
			@(negedge clk);
			item_valid = 1'b1;
			item       = r;
			@(posedge clk);
			while (item_stall)
				@(posedge clk);
			sent_count++;
		end
	endtask

	// Drop valid and wait until every result has come back
	task drain();
		begin
			@(negedge clk);
			item_valid = 1'b0;
			while (pending != 0)
				@(posedge clk);
			repeat (4) @(posedge clk);
		end
	endtask

	task set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
		begin
			reg_val[idx] = value;
			@(negedge clk);
			cfg_we    = 1'b1;
			cfg_index = idx;
			cfg_data  = value;
			@(negedge clk);
			cfg_we    = 1'b0;
		end
	endtask

	task apply_config(input logic [15:0] deb, input logic [15:0] settle,
			input logic [15:0] total, input logic [15:0] age, input logic [15:0] mag);
		int longest;
		begin
			set_reg(CFG_DEBOUNCE, deb);
			set_reg(CFG_SETTLE, settle);
			set_reg(CFG_TOTAL_TIMEOUT, total);
			set_reg(CFG_SENSOR_TIMEOUT, age);
			set_reg(CFG_DRIVE_MAG, mag);
			// time steps sized so patterns settle well inside the run time
			longest  = (deb > settle) ? deb : settle;
			step_max = ((total / 12 < longest / 3) ? total / 12 : longest / 3) + 1;
		end
	endtask

	// One alignment run: a start followed by segments of held beam patterns
	task run_alignment();
		logic [31:0] t;
		logic [1:0]  pat;
		int          u;
		int          segs;
		int          len;
		begin
			if ($urandom_range(99) < 30)
				t = 32'hFFFF_FFFF - $urandom_range(0, 3 * step_max + 50);
			else
				t = $urandom();
			send_req(mk_req(REQ_START, t, $urandom_range(99) >= 8, $urandom_range(1),
				$urandom_range(1), $urandom(), $urandom(), $urandom_range(1),
				$urandom_range(1)));
			segs = $urandom_range(1, 4);
			for (int s = 0; s < segs; s++) begin
				u = $urandom_range(99);
				if (u < 35)
					pat = PAT_CLEAR;
				else if (u < 60)
					pat = PAT_LEFT;
				else if (u < 85)
					pat = PAT_RIGHT;
				else
					pat = PAT_LEFT | PAT_RIGHT;
				len = $urandom_range(1, 10);
				for (int k = 0; k < len; k++) begin
					t = t + $urandom_range(0, step_max);
					if ($urandom_range(99) < 3)
						send_req(mk_noise());
					send_req(mk_tick(t, pat));
				end
			end
		end
	endtask

	initial begin
		logic [15:0] deb;
		logic [15:0] settle;
		logic [15:0] total;
		logic [15:0] age;
		int          quota;

		arst_n       = 1'b0;
		item_valid   = 1'b0;
		item         = '0;
		result_stall = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		hold_left    = 0;
		sent_count   = 0;
		tx_idle_pct  = 7;
		rx_idle_pct  = 45;
		reg_val[CFG_DEBOUNCE]       = RST_DEBOUNCE;
		reg_val[CFG_SETTLE]         = RST_SETTLE;
		reg_val[CFG_TOTAL_TIMEOUT]  = RST_TOTAL_TIMEOUT;
		reg_val[CFG_SENSOR_TIMEOUT] = RST_SENSOR_TIMEOUT;
		reg_val[CFG_DRIVE_MAG]      = RST_DRIVE_MAG;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: every request type, each fault, arrival, both drive signs, time wrap
		apply_config(16'd20, 16'd15, 16'd300, 16'd30, 16'd32767);
		send_req(mk_req(REQ_START, 32'd0, 0, 1, 1, 32'd0, 32'd0, 0, 0));
		send_req(mk_req(REQ_TICK, 32'd5, 1, 1, 1, 32'd5, 32'd5, 0, 0));
		send_req(mk_req(REQ_NONE, 32'd6, 1, 1, 1, 32'd6, 32'd6, 1, 1));
		send_req(mk_req(REQ_STOP, 32'd7, 1, 1, 1, 32'd7, 32'd7, 0, 0));
		send_req(mk_req(REQ_TICK, 32'd8, 1, 1, 1, 32'd8, 32'd8, 1, 0));
		send_req(mk_req(REQ_START, 32'd100, 1, 1, 1, 32'd100, 32'd100, 0, 0));
		send_req(mk_req(REQ_TICK, 32'd110, 0, 0, 1, 32'd110, 32'd110, 0, 0));
		send_req(mk_req(REQ_START, 32'd200, 1, 1, 1, 32'd200, 32'd200, 0, 0));
		send_req(mk_req(REQ_TICK, 32'd210, 0, 1, 1, 32'd210, 32'd170, 0, 0));
		send_req(mk_req(REQ_START, 32'd300, 1, 1, 1, 32'd300, 32'd300, 0, 0));
		send_req(mk_req(REQ_TICK, 32'd310, 0, 1, 1, 32'd310, 32'd310, 0, 0));
		send_req(mk_req(REQ_TICK, 32'd325, 0, 1, 1, 32'd295, 32'd325, 0, 0));
		send_req(mk_req(REQ_START, 32'hFFFF_FFF0, 1, 1, 1, 32'd0, 32'd0, 0, 0));
		send_req(mk_req(REQ_TICK, 32'hFFFF_FFFF, 1, 1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			1, 0));
		send_req(mk_req(REQ_TICK, 32'd19, 1, 1, 1, 32'd0, 32'd0, 1, 0));
		send_req(mk_req(REQ_TICK, 32'd20, 1, 1, 1, 32'd20, 32'd20, 0, 1));
		send_req(mk_req(REQ_TICK, 32'd40, 1, 1, 1, 32'd20, 32'd20, 0, 1));
		send_req(mk_req(REQ_TICK, 32'd41, 1, 1, 1, 32'd41, 32'd41, 1, 1));
		send_req(mk_req(REQ_TICK, 32'd61, 1, 1, 1, 32'd61, 32'd61, 1, 1));
		send_req(mk_req(REQ_START, 32'd1000, 1, 1, 1, 32'd1000, 32'd1000, 0, 0));
		send_req(mk_req(REQ_TICK, 32'd1301, 1, 1, 1, 32'd1301, 32'd1301, 0, 0));
		send_req(mk_req(REQ_START, 32'd2000, 1, 1, 1, 32'd2000, 32'd2000, 0, 0));
		send_req(mk_req(REQ_TICK, 32'd2300, 1, 1, 1, 32'd2300, 32'd2300, 0, 0));
		send_req(mk_req(REQ_STOP, 32'd2301, 1, 1, 1, 32'd2301, 32'd2301, 0, 0));
		send_req('1);

		// Random: six configuration phases, idling pattern changes every two
		for (int p = 0; p < 6; p++) begin
			drain();
			case (p)
				1: apply_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
				2: apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF);
				3: apply_config(RST_DEBOUNCE, RST_SETTLE, RST_TOTAL_TIMEOUT,
					RST_SENSOR_TIMEOUT, RST_DRIVE_MAG);
				5: begin
					deb    = $urandom_range(0, 30);
					settle = $urandom_range(0, 30);
					total  = $urandom_range(100, 400);
					age    = $urandom_range(0, 20);
					apply_config(deb, settle, total, age, $urandom_range(0, 32767));
				end
				default: begin
					deb    = $urandom_range(0, 120);
					settle = $urandom_range(0, 120);
					total  = $urandom_range(300, 1500);
					age    = $urandom_range(5, 60);
					apply_config(deb, settle, total, age, $urandom_range(0, 32767));
				end
			endcase
			case (p / 2)
				0: begin
					tx_idle_pct = 7;
					rx_idle_pct = 45;
				end
				1: begin
					tx_idle_pct = 45;
					rx_idle_pct = 7;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			// long receiver hold-off while the sender keeps offering
			if (p == 4) begin
				hold_left = 80;
				for (int b = 0; b < 3; b++)
					run_alignment();
			end
			quota = sent_count + 133;
			while (sent_count < quota) begin
				if ($urandom_range(99) < 10)
					send_req(mk_noise());
				else
					run_alignment();
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/bsla_pkg.sv
hw/rtl/beam_sensor_lateral_align_sequencer.sv
hw/rtl/bsla_checker.sv
tb/bsla_result_checker.sv
tb/tb.sv
